// ===== rtl/running_median_pairs_macros.svh =====
// assertion macros for the running median block
`ifndef RUNNING_MEDIAN_PAIRS_MACROS_SVH
`define RUNNING_MEDIAN_PAIRS_MACROS_SVH
// implication checked on every edge outside reset
`define RMP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define RMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/rmp_pkg.sv =====
// shared constants and types for the running median block
package rmp_pkg;
  localparam int CAPACITY = 1024;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PAIR = 1'b1;

  typedef struct packed {
    logic start;
    logic load;
    logic shift;
    logic rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic full;
  } sts_t;
endpackage

// ===== rtl/rmp_datapath.sv =====
// sorted store, insertion shifter and median read
module rmp_datapath import rmp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               func,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  output sts_t               sts,
  output logic signed [31:0] median,
  output logic               overflow
);
  logic signed [31:0] mem [CAPACITY];
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic               have_y;
  logic signed [31:0] rdata;
  logic               rvalid;
  logic               ovf;
  logic [CW:0]        need;
  logic               hit;
  logic [AW-1:0]      waddr;
  logic [CW-1:0]      mid;
  logic signed [31:0] result_med;
  logic               result_ovf;

  assign need = {1'b0, count} + (CW+1)'(2);
  assign sts.full = need > (CW+1)'(CAPACITY);
  assign hit = rvalid && (rdata > x);
  // reaching the bottom of the store (ptr at zero) ends the scan as well
  assign sts.scan_done = !hit;
  assign mid = (count - CW'(1)) >> 1;
  assign waddr = AW'(ptr);

  // ptr points at the free slot; rdata holds mem[ptr-1]
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rvalid <= 1'b0;
      have_y <= 1'b0;
      ovf <= 1'b0;
      result_med <= '0;
      result_ovf <= 1'b0;
    end else begin
      rvalid <= cmd.rd && (ptr != '0);
      if (cmd.start) begin
        ovf <= 1'b0;
        if (func == FUNC_START) begin
          count <= '0;
          ptr <= '0;
          x <= value_a;
          have_y <= 1'b0;
        end else if (sts.full) begin
          ovf <= 1'b1;
          have_y <= 1'b0;
        end else begin
          ptr <= count;
          x <= value_a;
          y <= value_b;
          have_y <= 1'b1;
        end
      end
      if (cmd.rd && (ptr != '0)) begin
        rdata <= mem[AW'(ptr - CW'(1))];
      end
      if (cmd.shift && hit) begin
        mem[waddr] <= rdata;
        ptr <= ptr - CW'(1);
      end
      if (cmd.load) begin
        mem[waddr] <= x;
        count <= count + CW'(1);
        if (have_y) begin
          x <= y;
          ptr <= count + CW'(1);
          have_y <= 1'b0;
        end
      end
      if (cmd.finish) begin
        if (count != '0) result_med <= mem[AW'(mid)];
        else result_med <= '0;
        result_ovf <= ovf;
      end
    end
  end

  assign median = result_med;
  assign overflow = result_ovf;
endmodule

// ===== rtl/rmp_ctrl.sv =====
// controller sequencing the insertion scan
module rmp_ctrl import rmp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic func,
  input  sts_t sts,
  output cmd_t cmd,
  output logic out_valid,
  input  logic out_ready
);
  `include "running_median_pairs_macros.svh"
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state, state_next;
  logic second, second_next;
  logic out_valid_next;
  logic ovf_path;

  assign in_ready = (state == S_IDLE);
  assign ovf_path = sts.full;

  always_comb begin
    state_next = state;
    second_next = second;
    out_valid_next = out_valid;
    cmd = '0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.start = 1'b1;
        second_next = 1'b0;
        if (func == FUNC_PAIR && ovf_path) state_next = S_FIN;
        else if (func == FUNC_START) state_next = S_WAIT;
        else state_next = S_READ;
      end
      S_WAIT: begin
        cmd.load = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.shift = 1'b1;
        if (sts.scan_done) begin
          cmd.load = 1'b1;
          if (!second) begin
            second_next = 1'b1;
            state_next = S_READ;
          end else state_next = S_FIN;
        end else state_next = S_READ;
      end
      S_FIN: if (!out_valid || out_ready) begin
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      second <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      second <= second_next;
      out_valid <= out_valid_next;
    end
  end

  `RMP_ASSERT_IMP(a_finish_room, cmd.finish, !out_valid || out_ready)
  `RMP_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)
  `RMP_ASSERT_IMP(a_busy_no_accept, state != S_IDLE, !in_ready)
endmodule

// ===== rtl/running_median_pairs.sv =====
// top level of the running median block
// channel  | signals                                 | direction
// request  | in_valid in_ready func value_a value_b  | in
// result   | out_valid out_ready median overflow     | out
// a start stores its value and returns to idle; a pair dropped on a full store
// goes straight to the finish step; a pair runs read and test steps for each
// of its two inserts in the one-port store scan, then the finish step
// the result sits in an output register from the cycle after the last step
// synchronous active-high reset clears the count; the store needs no clear
// a result still waiting holds the next pair at its last step until taken
module running_median_pairs import rmp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] median,
  output logic               overflow
);
  cmd_t cmd;
  sts_t sts;

  rmp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .sts(sts), .cmd(cmd), .out_valid(out_valid),
    .out_ready(out_ready)
  );

  rmp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .func(func), .value_a(value_a),
    .value_b(value_b), .sts(sts), .median(median), .overflow(overflow)
  );
endmodule
